@@ rtl/vrc_pkg.sv @@
// Shared types, fixed-point widths and helper functions of the volume ray compositor.
// Depends on nothing; imported by every other file of the block.
package vrc_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int SEG_SHIFT     = FRAC_BITS + 4;
    localparam int WORD_W        = 24;
    localparam int TR_W          = 17;
    localparam int X_W           = 32;
    localparam int EXP_W         = 33;
    localparam int EXP_DEPTH_DEF = 256;

    localparam logic [TR_W-1:0]   TR_ONE   = 17'h10000;
    localparam logic [WORD_W-1:0] WORD_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic load;
        logic upd_a;
        logic upd_b;
        logic upd_c;
        logic kill;
        logic clear;
    } t_lane_ctl;

    typedef struct packed {
        logic decide;
        logic clear;
    } t_merge_ctl;

    // Entry idx of the exp(-x) table, Q1.32; dq is the segment width in Q0.32.
    function automatic logic [EXP_W-1:0] exp_entry(input logic [63:0] dq, input int idx);
        logic [63:0] term;
        logic [63:0] r;
        logic [63:0] e;
        term = 64'd1 << 32;
        r    = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * dq) >> 32) / 64'(n);
            if (n % 2 == 1) begin
                r = r - term;
            end else begin
                r = r + term;
            end
        end
        e = 64'd1 << 32;
        for (int i = 1; i <= idx; i++) begin
            e = (e * r + (64'd1 << 31)) >> 32;
        end
        return e[EXP_W-1:0];
    endfunction

    function automatic logic [TR_W-1:0] mul_tr(input logic [TR_W-1:0] a,
                                               input logic [TR_W-1:0] b);
        logic [34:0] p;
        p = 35'(a) * 35'(b) + 35'd32768;
        return p[32:16];
    endfunction

    // (1-t)*a + t*b, rounded half up
    function automatic logic [TR_W-1:0] mix_tr(input logic [TR_W-1:0] a,
                                               input logic [TR_W-1:0] b,
                                               input logic [TR_W-1:0] t);
        logic [34:0] p;
        p = 35'(TR_ONE - t) * 35'(a) + 35'(t) * 35'(b) + 35'd32768;
        return p[32:16];
    endfunction

endpackage

@@ rtl/vrc_exp.sv @@
// Two-stage exp(-x) unit: table lookup of a segment, then linear interpolation.
// Depends on vrc_pkg for widths and the table entry function.
module vrc_exp import vrc_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic [X_W-1:0]  i_x,
    output logic [TR_W-1:0] o_e
);

    localparam int IW = $clog2(EXP_TABLE_DEPTH) + 1;
    localparam int PW = SEG_SHIFT + $clog2(EXP_TABLE_DEPTH + 1);
    localparam logic [63:0] DQ = (64'd16 << 32) / EXP_TABLE_DEPTH;
    localparam logic [X_W-1:0] X_LIMIT = X_W'(16) << FRAC_BITS;

    logic [EXP_W-1:0] w_tab [0:EXP_TABLE_DEPTH];

    genvar g;
    generate
        for (g = 0; g <= EXP_TABLE_DEPTH; g++) begin : g_tab
            assign w_tab[g] = exp_entry(DQ, g);
        end
    endgenerate

    logic [PW-1:0]        w_p;
    logic [IW-1:0]        w_idx;
    logic [IW-1:0]        w_idx1;
    logic                 w_zero;
    logic [EXP_W-1:0]     r_a;
    logic [EXP_W-1:0]     r_b;
    logic [SEG_SHIFT-1:0] r_f;
    logic                 r_zero;
    logic [EXP_W-1:0]     w_diff;
    logic [52:0]          w_prod;
    logic [EXP_W-1:0]     w_v;
    logic [33:0]          w_rnd;
    logic [TR_W-1:0]      r_e;

    always_comb begin
        w_zero = (i_x >= X_LIMIT);
        w_p    = PW'(i_x[SEG_SHIFT-1:0]) * PW'(EXP_TABLE_DEPTH);
        w_idx  = IW'(w_p >> SEG_SHIFT);
        w_idx1 = w_idx + IW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_a    <= w_tab[w_idx];
        r_b    <= w_tab[w_idx1];
        r_f    <= w_p[SEG_SHIFT-1:0];
        r_zero <= w_zero;
    end

    always_comb begin
        w_diff = r_a - r_b;
        w_prod = 53'(w_diff) * 53'(r_f);
        w_v    = r_a - w_prod[52:SEG_SHIFT];
        w_rnd  = 34'(w_v) + 34'd32768;
    end

    always_ff @(posedge i_clk) begin
        r_e <= r_zero ? '0 : w_rnd[32:16];
    end

    assign o_e = r_e;

endmodule

@@ rtl/vrc_lane.sv @@
// One color channel: optical depth, exp units, transmittance and luminance update.
// Depends on vrc_pkg and vrc_exp.
module vrc_lane import vrc_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_lane_ctl         i_ctl,
    input  logic [WORD_W-1:0] i_ext,
    input  logic [WORD_W-1:0] i_hold,
    input  logic [WORD_W-1:0] i_emis,
    input  logic [WORD_W-1:0] i_step,
    input  logic              i_sec,
    output logic [TR_W-1:0]   o_view,
    output logic [TR_W-1:0]   o_alpha,
    output logic [WORD_W-1:0] o_sum
);

    logic [WORD_W:0]   w_se_sum;
    logic [WORD_W-1:0] r_se;
    logic [WORD_W-1:0] r_sh;
    logic [WORD_W-1:0] r_lum;
    logic [WORD_W-1:0] r_step;
    logic              r_sec;
    logic [47:0]       w_pe;
    logic [47:0]       w_ph;
    logic [X_W-1:0]    r_xe;
    logic [X_W-1:0]    r_xh;
    logic [TR_W-1:0]   w_ee;
    logic [TR_W-1:0]   w_eh;
    logic [40:0]       w_p1;
    logic [41:0]       w_p2;
    logic [48:0]       w_p3;
    logic [WORD_W:0]   r_t1;
    logic [WORD_W:0]   r_t2;
    logic [32:0]       r_add;
    logic [33:0]       w_sum;
    logic [TR_W-1:0]   r_view;
    logic [TR_W-1:0]   r_holdt;
    logic [TR_W-1:0]   r_alpha;
    logic [TR_W-1:0]   r_matte;
    logic [WORD_W-1:0] r_sum;

    assign w_se_sum = 25'(i_ext) + 25'(i_hold);

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (i_sec) begin
                r_se <= w_se_sum[WORD_W] ? WORD_MAX : w_se_sum[WORD_W-1:0];
            end else begin
                r_se <= i_ext;
            end
            r_sh   <= i_hold;
            r_lum  <= i_emis;
            r_step <= i_step;
            r_sec  <= i_sec;
        end
    end

    // optical depth, truncated
    assign w_pe = 48'(r_se) * 48'(r_step);
    assign w_ph = 48'(r_sh) * 48'(r_step);

    always_ff @(posedge i_clk) begin
        r_xe <= w_pe[47:FRAC_BITS];
        r_xh <= w_ph[47:FRAC_BITS];
    end

    vrc_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_e (
        .i_clk (i_clk),
        .i_x   (r_xe),
        .o_e   (w_ee)
    );

    vrc_exp #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_exp_h (
        .i_clk (i_clk),
        .i_x   (r_xh),
        .o_e   (w_eh)
    );

    // luminance weighting chain, each product sees the state updated before it
    assign w_p1 = 41'(r_lum) * 41'(r_view) + 41'd32768;
    assign w_p2 = 42'(r_t1) * 42'(r_holdt) + 42'd32768;
    assign w_p3 = 49'(r_t2) * 49'(r_step) + 49'd32768;

    always_ff @(posedge i_clk) begin
        r_t1  <= w_p1[40:16];
        r_t2  <= w_p2[40:16];
        r_add <= w_p3[48:16];
    end

    assign w_sum = 34'(r_sum) + 34'(r_add);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_view  <= TR_ONE;
            r_holdt <= TR_ONE;
            r_alpha <= TR_ONE;
            r_matte <= '0;
            r_sum   <= '0;
        end else if (i_ctl.kill) begin
            r_view  <= '0;
            r_alpha <= '0;
        end else begin
            if (i_ctl.upd_a) begin
                r_view <= mul_tr(r_view, w_ee);
                if (!r_sec) begin
                    r_holdt <= mul_tr(r_holdt, w_eh);
                    r_matte <= mix_tr(r_alpha, r_matte, w_eh);
                end
            end
            if (i_ctl.upd_b && !r_sec) begin
                r_alpha <= mix_tr(r_matte, r_alpha, w_ee);
            end
            if (i_ctl.upd_c) begin
                r_sum <= (w_sum > 34'(WORD_MAX)) ? WORD_MAX : w_sum[WORD_W-1:0];
            end
        end
    end

    assign o_view  = r_view;
    assign o_alpha = r_alpha;
    assign o_sum   = r_sum;

endmodule

@@ rtl/vrc_merge.sv @@
// Merge stage: largest view transmittance across lanes and the early-stop decision.
// Depends on vrc_pkg for widths and the control struct.
module vrc_merge import vrc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_merge_ctl           i_ctl,
    input  logic [2:0][TR_W-1:0] i_view,
    input  logic                 i_es_en,
    input  logic [TR_W-1:0]      i_es_thr,
    output logic                 o_kill,
    output logic                 o_stopped
);

    logic [TR_W-1:0] w_max01;
    logic [TR_W-1:0] w_max;
    logic            r_stopped;

    always_comb begin
        w_max01 = (i_view[1] > i_view[0]) ? i_view[1] : i_view[0];
        w_max   = (i_view[2] > w_max01) ? i_view[2] : w_max01;
        o_kill  = i_ctl.decide && i_es_en && (w_max < i_es_thr);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_stopped <= 1'b0;
        end else if (o_kill) begin
            r_stopped <= 1'b1;
        end
    end

    assign o_stopped = r_stopped;

endmodule

@@ rtl/volume_ray_compositor.sv @@
// Volume ray compositor: front-to-back compositing of raymarch samples, three color lanes.
// A new sample is accepted only after the previous result has been drained; each sample
// runs the per-lane chain of optical depth, exp lookup and interpolation, transmittance
// update and three luminance products.
// Reset (synchronous, active low) clears the ray state and loads register defaults.
// Depends on vrc_pkg, vrc_lane (with vrc_exp) and vrc_merge.
module volume_ray_compositor import vrc_pkg::*; #(
    parameter int EXP_TABLE_DEPTH = EXP_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic          i_cfg_index,
    input  logic [16:0]   i_cfg_data,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // extinction r,g,b; holdout r,g,b; emission r,g,b; step_size (24 bits each)
    input  logic [239:0]  s_axis_tdata,
    // secondary_ray
    input  logic          s_axis_tuser,
    input  logic          s_axis_tlast,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // radiance r,g,b (24 bits each); opacity r,g,b (17 bits each); zero pad
    output logic [127:0]  m_axis_tdata,
    // terminated
    output logic          m_axis_tuser,
    output logic          m_axis_tlast
);

    localparam logic REG_ES_EN  = 1'b0;
    localparam logic REG_ES_THR = 1'b1;

    localparam logic [3:0] PH_IDLE  = 4'd0;
    localparam logic [3:0] PH_UPD_A = 4'd4;
    localparam logic [3:0] PH_UPD_B = 4'd5;
    localparam logic [3:0] PH_UPD_C = 4'd8;
    localparam logic [3:0] PH_STOP  = 4'd9;
    localparam logic [3:0] PH_DONE  = 4'd10;

    logic                 r_es_en;
    logic [TR_W-1:0]      r_es_thr;
    logic [3:0]           r_phase;
    logic [3:0]           n_phase;
    logic                 r_sec;
    logic                 r_last;
    logic                 w_accept;
    logic                 w_fire;
    logic                 w_active;
    logic                 w_kill;
    logic                 w_stopped;
    t_lane_ctl            w_lane_ctl;
    t_merge_ctl           w_merge_ctl;
    logic [2:0][TR_W-1:0] w_view;
    logic [2:0][TR_W-1:0] w_alpha;
    logic [2:0][WORD_W-1:0] w_sum;
    logic                 r_out_valid;
    logic [127:0]         r_out_data;
    logic                 r_out_term;
    logic                 r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_es_en  <= 1'b1;
            r_es_thr <= 17'd66;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ES_EN:  r_es_en  <= i_cfg_data[0];
                REG_ES_THR: r_es_thr <= i_cfg_data;
                default:    r_es_en  <= r_es_en;
            endcase
        end
    end

    assign s_axis_tready = (r_phase == PH_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    // drain the finished sample only when the output register is free
    assign w_fire        = (r_phase == PH_DONE) && (!r_out_valid || m_axis_tready);
    assign w_active      = !w_stopped;

    always_comb begin
        n_phase = r_phase;
        if (r_phase == PH_IDLE) begin
            if (w_accept) begin
                n_phase = r_phase + 4'd1;
            end
        end else if (r_phase == PH_DONE) begin
            if (w_fire) begin
                n_phase = PH_IDLE;
            end
        end else begin
            n_phase = r_phase + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_sec  <= s_axis_tuser;
            r_last <= s_axis_tlast;
        end
    end

    always_comb begin
        w_lane_ctl.load   = w_accept;
        w_lane_ctl.upd_a  = (r_phase == PH_UPD_A) && w_active;
        w_lane_ctl.upd_b  = (r_phase == PH_UPD_B) && w_active;
        w_lane_ctl.upd_c  = (r_phase == PH_UPD_C) && w_active;
        w_lane_ctl.kill   = w_kill;
        w_lane_ctl.clear  = w_fire && r_last;
        w_merge_ctl.decide = (r_phase == PH_STOP) && w_active;
        w_merge_ctl.clear  = w_fire && r_last;
    end

    genvar c;
    generate
        for (c = 0; c < 3; c++) begin : g_lane
            vrc_lane #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_lane_ctl),
                .i_ext   (s_axis_tdata[c*WORD_W +: WORD_W]),
                .i_hold  (s_axis_tdata[(3+c)*WORD_W +: WORD_W]),
                .i_emis  (s_axis_tdata[(6+c)*WORD_W +: WORD_W]),
                .i_step  (s_axis_tdata[9*WORD_W +: WORD_W]),
                .i_sec   (s_axis_tuser),
                .o_view  (w_view[c]),
                .o_alpha (w_alpha[c]),
                .o_sum   (w_sum[c])
            );
        end
    endgenerate

    vrc_merge u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (w_merge_ctl),
        .i_view    (w_view),
        .i_es_en   (r_es_en),
        .i_es_thr  (r_es_thr),
        .o_kill    (w_kill),
        .o_stopped (w_stopped)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_data <= {5'b0,
                           r_sec ? w_view[2] : w_alpha[2],
                           r_sec ? w_view[1] : w_alpha[1],
                           r_sec ? w_view[0] : w_alpha[0],
                           w_sum[2], w_sum[1], w_sum[0]};
            r_out_term <= w_stopped;
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_term;
    assign m_axis_tlast  = r_out_last;

endmodule

@@ sim/vrc_checker.sv @@
// Checker for the volume ray compositor: it watches the sample, result and register channels.
// It predicts every result with its own fixed-point compositor and compares each field.
// Depends on nothing but the channel signals; the testbench top instantiates it.
`timescale 1ns / 100ps

module vrc_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [16:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [239:0] s_axis_tdata,
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    input  logic         m_axis_tlast,
    output int           o_errors,
    output int           o_pending
);
    localparam int FB = 16;
    localparam int DEPTH = 256;
    localparam longint unsigned ONE = 64'd1 << FB;
    localparam longint unsigned WMAX = 64'hFFFFFF;

    typedef struct packed {
        logic [2:0][23:0] radiance;
        logic [2:0][16:0] opacity;
        logic             stopped;
        logic             ray_end;
    } pixel_t;

    longint unsigned exp_lut [0:DEPTH];
    longint unsigned rad [3];
    longint unsigned view_tr [3];
    longint unsigned hold_tr [3];
    longint unsigned alpha_tr [3];
    longint unsigned matte_tr [3];
    logic            halted;
    logic            stop_en;
    logic [16:0]     stop_level;
    pixel_t          pixel_q [$];

    initial begin
        longint unsigned seg, term, ratio;
        seg = (64'd16 << 32) / DEPTH;
        term = 64'd1 << 32;
        ratio = term;
        for (int n = 1; n <= 12; n++) begin
            term = ((term * seg) >> 32) / n;
            if (n % 2 == 1) begin
                ratio = ratio - term;
            end else begin
                ratio = ratio + term;
            end
        end
        exp_lut[0] = 64'd1 << 32;
        for (int i = 1; i <= DEPTH; i++) begin
            exp_lut[i] = (exp_lut[i-1] * ratio + (64'd1 << 31)) >> 32;
        end
    end

    assign o_pending = pixel_q.size();

    function automatic longint unsigned exp_neg(longint unsigned x);
        longint unsigned p, idx, f, a, b, v;
        if (x >= (64'd16 << FB)) begin
            return 0;
        end
        p = x * DEPTH;
        idx = p >> (FB + 4);
        f = p & ((64'd1 << (FB + 4)) - 1);
        a = exp_lut[idx];
        b = exp_lut[idx + 1];
        v = a - (((a - b) * f) >> (FB + 4));
        return (v + (64'd1 << (31 - FB))) >> (32 - FB);
    endfunction

    function automatic longint unsigned fx_mul(longint unsigned a, longint unsigned b);
        return (a * b + (ONE >> 1)) >> FB;
    endfunction

    function automatic longint unsigned fx_lerp(longint unsigned a, longint unsigned b,
                                                longint unsigned t);
        return ((ONE - t) * a + t * b + (ONE >> 1)) >> FB;
    endfunction

    function automatic void clear_ray();
        for (int c = 0; c < 3; c++) begin
            rad[c] = 0;
            view_tr[c] = ONE;
            hold_tr[c] = ONE;
            alpha_tr[c] = ONE;
            matte_tr[c] = 0;
        end
        halted = 0;
    endfunction

    function automatic pixel_t composite(logic [239:0] d, logic sec, logic last);
        pixel_t px;
        longint unsigned stp, se, sh, lum, eh, ee, s, vmax;
        stp = d[216 +: 24];
        if (!halted) begin
            for (int c = 0; c < 3; c++) begin
                se = d[24*c +: 24];
                sh = d[24*(3+c) +: 24];
                lum = d[24*(6+c) +: 24];
                eh = ONE;
                if (sec) begin
                    se = se + sh;
                    if (se > WMAX) se = WMAX;
                end else begin
                    eh = exp_neg((sh * stp) >> FB);
                    hold_tr[c] = fx_mul(hold_tr[c], eh);
                end
                ee = exp_neg((se * stp) >> FB);
                view_tr[c] = fx_mul(view_tr[c], ee);
                if (!sec) begin
                    matte_tr[c] = fx_lerp(alpha_tr[c], matte_tr[c], eh);
                    alpha_tr[c] = fx_lerp(matte_tr[c], alpha_tr[c], ee);
                end
                s = rad[c] + fx_mul(fx_mul(fx_mul(lum, view_tr[c]), hold_tr[c]), stp);
                rad[c] = (s > WMAX) ? WMAX : s;
            end
            vmax = view_tr[0];
            if (view_tr[1] > vmax) vmax = view_tr[1];
            if (view_tr[2] > vmax) vmax = view_tr[2];
            if (stop_en && vmax < stop_level) begin
                for (int c = 0; c < 3; c++) begin
                    view_tr[c] = 0;
                    alpha_tr[c] = 0;
                end
                halted = 1;
            end
        end
        for (int c = 0; c < 3; c++) begin
            px.radiance[c] = rad[c][23:0];
            px.opacity[c] = sec ? view_tr[c][16:0] : alpha_tr[c][16:0];
        end
        px.stopped = halted;
        px.ray_end = last;
        if (last) clear_ray();
        return px;
    endfunction

    task automatic report(string what, longint unsigned want, longint unsigned got);
        $display("%0t: mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        pixel_t want;
        if (!i_rst_n) begin
            stop_en <= 1'b1;
            stop_level <= 17'd66;
            clear_ray();
            pixel_q.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == 1'b0) begin
                    stop_en <= i_cfg_data[0];
                end else begin
                    stop_level <= i_cfg_data;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                pixel_q.push_back(composite(s_axis_tdata, s_axis_tuser, s_axis_tlast));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pixel_q.size() == 0) begin
                    report("unexpected result", 0, m_axis_tdata);
                end else begin
                    want = pixel_q.pop_front();
                    for (int c = 0; c < 3; c++) begin
                        if (m_axis_tdata[24*c +: 24] != want.radiance[c])
                            report($sformatf("radiance[%0d]", c), want.radiance[c],
                                   m_axis_tdata[24*c +: 24]);
                        if (m_axis_tdata[72 + 17*c +: 17] != want.opacity[c])
                            report($sformatf("opacity[%0d]", c), want.opacity[c],
                                   m_axis_tdata[72 + 17*c +: 17]);
                    end
                    if (m_axis_tdata[127:123] != 5'd0)
                        report("pad bits", 0, m_axis_tdata[127:123]);
                    if (m_axis_tuser !== want.stopped)
                        report("terminated", want.stopped, m_axis_tuser);
                    if (m_axis_tlast !== want.ray_end)
                        report("ray_end", want.ray_end, m_axis_tlast);
                end
            end
        end
    end

endmodule

@@ sim/tb_volume_ray_compositor.sv @@
// Testbench top for the volume ray compositor: clock, reset, register writes and samples.
// Depends on volume_ray_compositor and vrc_checker, which does all result checking.
`timescale 1ns / 100ps

module tb_volume_ray_compositor;
    localparam int ITEMS = 850;
    localparam logic CFG_ENABLE = 1'b0;
    localparam logic CFG_LEVEL  = 1'b1;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic         i_cfg_index = 1'b0;
    logic [16:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [239:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         s_axis_tlast = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         m_axis_tlast;
    int           errors;
    int           pending;
    logic         calm = 1'b0;

    always #5 i_clk = ~i_clk;

    volume_ray_compositor i_dut (.*);

    vrc_checker u_checker (.*, .o_errors(errors), .o_pending(pending));

    function automatic int gap_len();
        if (calm) return 0;
        case ($urandom_range(0, 19))
            0:             return $urandom_range(10, 40);
            1, 2, 3, 4, 5: return $urandom_range(1, 3);
            default:       return 0;
        endcase
    endfunction

    // Mixed magnitudes so that rays live several steps, with full-range values as well.
    function automatic logic [23:0] coeff();
        case ($urandom_range(0, 5))
            0:       return 24'($urandom);
            1:       return 24'd0;
            2:       return 24'hFFFFFF;
            default: return 24'($urandom & ((32'd1 << $urandom_range(0, 18)) - 1));
        endcase
    endfunction

    always @(posedge i_clk) begin
        m_axis_tready <= (calm || gap_len() == 0);
    end

    initial begin
        #5000000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send(logic [2:0][23:0] ext, logic [2:0][23:0] hold,
                        logic [2:0][23:0] lum, logic [23:0] stp, logic sec, logic last);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_axis_tdata <= {stp, lum, hold, ext};
        s_axis_tuser <= sec;
        s_axis_tlast <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic send_random(logic last);
        logic [23:0] stp;
        stp = ($urandom_range(0, 9) == 0) ? coeff() : 24'($urandom & 32'h03FFFF);
        send({coeff(), coeff(), coeff()}, {coeff(), coeff(), coeff()},
             {coeff(), coeff(), coeff()}, stp, $urandom_range(0, 3) == 0, last);
    endtask

    task automatic write_reg(logic idx, logic [16:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_rays(int count);
        int len;
        while (count > 0) begin
            len = $urandom_range(1, 12);
            for (int k = 1; k <= len && count > 0; k++) begin
                send_random(k == len || $urandom_range(0, 30) == 0);
                count--;
            end
            calm = ($urandom_range(0, 5) == 0);
        end
    endtask

    initial begin
        int wait_cycles;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, both ray kinds, termination and samples after it
        send('0, '0, '0, '0, 1'b0, 1'b0);
        send('1, '1, '1, '1, 1'b0, 1'b1);
        send('1, '1, '1, '1, 1'b1, 1'b1);
        send({3{24'h000100}}, {3{24'h000200}}, {3{24'h010000}}, 24'h004000, 1'b0, 1'b0);
        send({3{24'h000100}}, {3{24'h000200}}, {3{24'hFFFFFF}}, 24'hFFFFFF, 1'b1, 1'b0);
        send({3{24'h000100}}, {3{24'h000200}}, {3{24'h020000}}, 24'h010000, 1'b0, 1'b0);
        send({3{24'hFF0000}}, {3{24'h00FFFF}}, {3{24'hFFFFFF}}, 24'h00FFFF, 1'b1, 1'b0);
        send({3{24'h000100}}, '0, {3{24'hFFFFFF}}, 24'h010000, 1'b0, 1'b0);
        send({3{24'h000100}}, '0, {3{24'hFFFFFF}}, 24'h010000, 1'b1, 1'b1);
        send({24'h0, 24'h0, 24'h100000}, {3{24'h000800}}, {3{24'h008000}},
             24'h018000, 1'b0, 1'b0);
        send({24'h0, 24'h0, 24'h100000}, {3{24'h000800}}, {3{24'h008000}},
             24'h018000, 1'b0, 1'b1);
        send({3{24'h080000}}, '0, {3{24'h010000}}, 24'h010000, 1'b0, 1'b1);

        write_reg(CFG_ENABLE, 17'd0);
        send({3{24'hFFFFFF}}, '0, {3{24'h010000}}, 24'h100000, 1'b0, 1'b0);
        send({3{24'h000100}}, '0, {3{24'h010000}}, 24'h010000, 1'b0, 1'b1);
        random_rays(160);

        write_reg(CFG_ENABLE, 17'd1);
        write_reg(CFG_LEVEL, 17'h10000);
        send({3{24'h000001}}, '0, {3{24'h000001}}, 24'h000001, 1'b0, 1'b0);
        send('0, '0, '0, '0, 1'b1, 1'b1);
        random_rays(160);

        write_reg(CFG_LEVEL, 17'd0);
        random_rays(160);

        write_reg(CFG_LEVEL, 17'h01000 + 17'($urandom_range(0, 16'hEFFF)));
        random_rays(170);

        write_reg(CFG_LEVEL, 17'd66);
        random_rays(ITEMS - 670);

        s_axis_tvalid <= 1'b0;
        calm = 1'b0;
        wait_cycles = 0;
        while (pending != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (30) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ volume_ray_compositor.f @@
rtl/vrc_pkg.sv
rtl/vrc_exp.sv
rtl/vrc_lane.sv
rtl/vrc_merge.sv
rtl/volume_ray_compositor.sv
sim/vrc_checker.sv
sim/tb_volume_ray_compositor.sv
